[src/bpct_pkg.sv]
// Package for the binary prefix-code trie: codes, defaults and the
// command/status bundles shared by the controller and the datapath.
// No dependencies.
package bpct_pkg;

    localparam int NODE_COUNT_DEF = 256;
    localparam int MAX_PREFIX_DEF = 16;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_CHAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_CHAR = 2'd1;

    localparam logic [7:0] LEFT_CHAR_RST  = 8'd48;
    localparam logic [7:0] RIGHT_CHAR_RST = 8'd49;
    localparam logic [7:0] EMPTY_SYMBOL   = 8'd32;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_POOL_FULL = 3'd4;

    typedef struct packed {
        logic capture;
        logic eval;
        logic alloc;
    } t_dp_cmd;

    typedef struct packed {
        logic in_needs_result;
        logic has_result;
        logic alloc_req;
    } t_dp_status;

endpackage

[src/binary_prefix_code_trie_top.sv]
// Binary prefix-code trie, top level: controller plus datapath.
// Depends on bpct_pkg, bpct_ctrl and bpct_datapath.
//
// Prefixes arrive one character per transfer and close with an end-of-prefix
// transfer; insert stores a symbol at the node reached, lookup returns it, and
// clear resets the table to a lone root. Each item is accepted in the idle
// state, then evaluated against the registered read of the node memory at
// the current walk position. An insert character that creates a node also
// passes an allocate state, since the parent pointer update and the new node
// share the one memory write port. End and clear items write their result to
// the output register when evaluated; character items give no result. The
// node memory needs no clearing pass after reset, and configuration writes
// are always accepted and must be made while the block is idle.
module binary_prefix_code_trie_top #(
    parameter int NODE_COUNT = bpct_pkg::NODE_COUNT_DEF,
    parameter int MAX_PREFIX = bpct_pkg::MAX_PREFIX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bpct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_mode,
    input  logic [7:0]                     i_prefix_char,
    input  logic                           i_end_of_prefix,
    input  logic [7:0]                     i_symbol,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_status,
    output logic [7:0]                     o_found_symbol
);
    import bpct_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status stat;

    assign o_cfg_ready = 1'b1;

    bpct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bpct_datapath #(
        .NODE_COUNT (NODE_COUNT),
        .MAX_PREFIX (MAX_PREFIX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_prefix_char   (i_prefix_char),
        .i_end_of_prefix (i_end_of_prefix),
        .i_symbol        (i_symbol),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_status        (o_status),
        .o_found_symbol  (o_found_symbol)
    );

endmodule

[src/bpct_datapath.sv]
// Datapath of the prefix-code trie: config registers, item registers,
// root node, node memory, walk state and the result register.
// Depends on bpct_pkg.
module bpct_datapath #(
    parameter int NODE_COUNT = bpct_pkg::NODE_COUNT_DEF,
    parameter int MAX_PREFIX = bpct_pkg::MAX_PREFIX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic [1:0]                     i_mode,
    input  logic [7:0]                     i_prefix_char,
    input  logic                           i_end_of_prefix,
    input  logic [7:0]                     i_symbol,
    input  bpct_pkg::t_dp_cmd              i_cmd,
    output bpct_pkg::t_dp_status           o_stat,
    output logic [2:0]                     o_status,
    output logic [7:0]                     o_found_symbol
);
    import bpct_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);
    localparam int UW = $clog2(NODE_COUNT + 1);
    localparam int PW = $clog2(MAX_PREFIX + 2);
    localparam int WW = 2 * AW + 8;
    localparam logic [UW-1:0] NODE_LIMIT = UW'(NODE_COUNT);
    localparam logic [PW-1:0] POS_MAX    = PW'(MAX_PREFIX);

    logic [7:0]    r_left_char;
    logic [7:0]    r_right_char;
    logic [1:0]    r_mode;
    logic [7:0]    r_char;
    logic          r_end;
    logic [7:0]    r_sym;
    logic [AW-1:0] r_root_left;
    logic [AW-1:0] r_root_right;
    logic [7:0]    r_root_sym;
    logic [UW-1:0] r_used;
    logic [AW-1:0] r_walk;
    logic [PW-1:0] r_pos;
    logic [2:0]    r_err;
    logic [WW-1:0] r_rdata;
    logic [2:0]    r_status;
    logic [7:0]    r_found;

    logic [WW-1:0] mem [NODE_COUNT];

    logic          at_root;
    logic [AW-1:0] node_left;
    logic [AW-1:0] node_right;
    logic [7:0]    node_sym;
    logic          hit_left;
    logic          hit_right;
    logic [AW-1:0] child;
    logic [AW-1:0] new_child;
    logic          child_missing;
    logic          is_item;
    logic          is_char;
    logic [2:0]    walk_err;
    logic [2:0]    char_err;
    logic          alloc;
    logic          store;
    logic [2:0]    res_status;
    logic [7:0]    res_found;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [WW-1:0] mem_wdata;

    assign at_root    = (r_walk == '0);
    assign node_left  = at_root ? r_root_left  : r_rdata[WW-1 -: AW];
    assign node_right = at_root ? r_root_right : r_rdata[AW+7 -: AW];
    assign node_sym   = at_root ? r_root_sym   : r_rdata[7:0];
    assign hit_left   = (r_char == r_left_char);
    assign hit_right  = !hit_left && (r_char == r_right_char);
    assign child      = hit_left ? node_left : node_right;
    assign new_child  = r_used[AW-1:0];
    assign child_missing = (hit_left || hit_right) && (child == '0);
    assign is_item    = (r_mode == MODE_INSERT) || (r_mode == MODE_LOOKUP);
    assign is_char    = is_item && !r_end && (r_err == ST_OK);

    always_comb begin
        walk_err = ST_OK;
        if (child_missing) begin
            if (r_mode == MODE_LOOKUP) begin
                walk_err = ST_NOT_FOUND;
            end else if (r_used == NODE_LIMIT) begin
                walk_err = ST_POOL_FULL;
            end
        end
        if (walk_err != ST_OK) begin
            char_err = walk_err;
        end else if (r_pos >= POS_MAX) begin
            char_err = ST_TOO_LONG;
        end else begin
            char_err = ST_OK;
        end
    end

    assign alloc = is_char && child_missing && (r_mode == MODE_INSERT) &&
                   (r_used != NODE_LIMIT);
    assign store = is_item && r_end && (r_mode == MODE_INSERT) &&
                   (r_pos != '0) && (r_err == ST_OK);

    always_comb begin
        res_status = ST_OK;
        res_found  = 8'd0;
        if (r_mode != MODE_CLEAR) begin
            if (r_pos == '0) begin
                res_status = ST_EMPTY;
            end else if (r_err != ST_OK) begin
                res_status = r_err;
            end else if (r_mode == MODE_LOOKUP) begin
                if (node_sym == EMPTY_SYMBOL) begin
                    res_status = ST_NOT_FOUND;
                end else begin
                    res_found = node_sym;
                end
            end
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_walk;
        mem_wdata = {node_left, node_right, r_sym};
        if (i_cmd.alloc) begin
            mem_we    = 1'b1;
            mem_waddr = new_child;
            mem_wdata = {{AW{1'b0}}, {AW{1'b0}}, EMPTY_SYMBOL};
        end else if (i_cmd.eval && !at_root) begin
            if (alloc) begin
                mem_we    = 1'b1;
                mem_wdata = hit_left ? {new_child, node_right, node_sym}
                                     : {node_left, new_child, node_sym};
            end else if (store) begin
                mem_we = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[r_walk];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_char <= i_prefix_char;
            r_end  <= i_end_of_prefix;
            r_sym  <= i_symbol;
        end
        if (i_cmd.eval && o_stat.has_result) begin
            r_status <= res_status;
            r_found  <= res_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_char  <= LEFT_CHAR_RST;
            r_right_char <= RIGHT_CHAR_RST;
            r_root_left  <= '0;
            r_root_right <= '0;
            r_root_sym   <= EMPTY_SYMBOL;
            r_used       <= UW'(1);
            r_walk       <= '0;
            r_pos        <= '0;
            r_err        <= ST_OK;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_LEFT_CHAR:  r_left_char  <= i_cfg_data;
                    REG_RIGHT_CHAR: r_right_char <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.eval) begin
                if (r_mode == MODE_CLEAR) begin
                    r_root_left  <= '0;
                    r_root_right <= '0;
                    r_root_sym   <= EMPTY_SYMBOL;
                    r_used       <= UW'(1);
                    r_walk       <= '0;
                    r_pos        <= '0;
                    r_err        <= ST_OK;
                end else if (is_item && r_end) begin
                    if (store && at_root) begin
                        r_root_sym <= r_sym;
                    end
                    r_walk <= '0;
                    r_pos  <= '0;
                    r_err  <= ST_OK;
                end else if (is_char) begin
                    if ((hit_left || hit_right) && !child_missing) begin
                        r_walk <= child;
                    end
                    if (alloc && at_root) begin
                        if (hit_left) begin
                            r_root_left <= new_child;
                        end else begin
                            r_root_right <= new_child;
                        end
                    end
                    r_err <= char_err;
                    if (r_pos <= POS_MAX) begin
                        r_pos <= r_pos + PW'(1);
                    end
                end
            end
            if (i_cmd.alloc) begin
                r_walk <= new_child;
                r_used <= r_used + UW'(1);
            end
        end
    end

    assign o_stat.in_needs_result = (i_mode == MODE_CLEAR) ||
                                    (i_end_of_prefix && (i_mode != MODE_UNUSED));
    assign o_stat.has_result = (r_mode == MODE_CLEAR) || (is_item && r_end);
    assign o_stat.alloc_req  = alloc;
    assign o_status          = r_status;
    assign o_found_symbol    = r_found;

endmodule

[src/bpct_ctrl.sv]
// Controller of the prefix-code trie: item sequencing and output valid.
// Depends on bpct_pkg.
module bpct_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  bpct_pkg::t_dp_status i_stat,
    output bpct_pkg::t_dp_cmd    o_cmd
);
    import bpct_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_ALLOC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    assign o_in_ready = (r_state == S_IDLE) &&
                        (!r_out_valid || i_out_ready || !i_stat.in_needs_result);

    assign o_cmd.capture = i_in_valid && o_in_ready;
    assign o_cmd.eval    = (r_state == S_EVAL);
    assign o_cmd.alloc   = (r_state == S_ALLOC);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = i_stat.alloc_req ? S_ALLOC : S_IDLE;
            end
            S_ALLOC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.eval && i_stat.has_result) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[src/bpct_checker.sv]
// Port-level checker for the binary prefix-code trie, bound to the top.
// Depends on bpct_pkg and binary_prefix_code_trie_top.
module bpct_assertions (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_mode,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_status,
    input logic [7:0] o_found_symbol
);
    import bpct_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_POOL_FULL))
        else $error("status code out of range");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_found_symbol == 8'd0))
        else $error("symbol returned with error status");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_mode == MODE_CLEAR) |=> !o_in_ready)
        else $error("new item taken during clear");

    a_clear_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_mode == MODE_CLEAR) |->
            ##2 (o_out_valid && (o_status == ST_OK)))
        else $error("clear did not answer ok");

endmodule

bind binary_prefix_code_trie_top bpct_assertions u_bpct_assertions (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_mode         (i_mode),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_found_symbol (o_found_symbol)
);
